FILE: hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Blue blob centroid package
// Shared widths, limits, sequencer states and status types of the block.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int FRAME_DIM_MAX = 1024;
  localparam int COORD_W       = $clog2(FRAME_DIM_MAX);

  localparam int COLOR_W    = 8;
  localparam int HEIGHT_W   = 11;
  localparam int SUM_W      = 30;
  localparam int HIT_W      = 21;
  localparam int CENTRE_W   = 10;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1024;

  // Effective height needs room for FRAME_DIM_MAX and for row + 1.
  localparam int EH_W = (COORD_W + 1 > HEIGHT_W) ? COORD_W + 1 : HEIGHT_W;

  // Divisor shifted up to the top quotient bit, and the compare width.
  localparam int DVS_W  = HIT_W + COORD_W - 1;
  localparam int CMP_W  = (SUM_W > DVS_W) ? SUM_W : DVS_W;
  localparam int ITER_W = $clog2(COORD_W + 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_X,
    ST_DIV_X,
    ST_START_Y,
    ST_DIV_Y,
    ST_OUT
  } bbc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bbc_div_stat_t;

endpackage

FILE: hw/rtl/bbc_accum.sv
// ----------------------------------------------------------------------------
// Blue blob centroid accumulator
// Counts pixel coordinates, tests the blue threshold and sums qualifying hits.
// ----------------------------------------------------------------------------
module bbc_accum import bbc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pix_valid,
  input  logic [COLOR_W-1:0]  red,
  input  logic [COLOR_W-1:0]  green,
  input  logic [COLOR_W-1:0]  blue,
  input  logic [HEIGHT_W-1:0] height,
  input  logic                clear,
  output logic [SUM_W-1:0]    col_sum,
  output logic [SUM_W-1:0]    row_sum,
  output logic [HIT_W-1:0]    hit_count
);

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0]   col_sum_r, col_sum_nxt;
  logic [SUM_W-1:0]   row_sum_r, row_sum_nxt;
  logic [HIT_W-1:0]   hit_r, hit_nxt;

  logic [COLOR_W+2:0] red_x5;
  logic [COLOR_W+2:0] green_x5;
  logic [COLOR_W+2:0] blue_ext;
  logic               qualify;
  logic [SUM_W:0]     col_sum_add;
  logic [SUM_W:0]     row_sum_add;
  logic               room;
  logic [EH_W-1:0]    eff_h;
  logic [EH_W-1:0]    row_inc;

  assign red_x5   = ((COLOR_W+3)'(red) << 2) + (COLOR_W+3)'(red);
  assign green_x5 = ((COLOR_W+3)'(green) << 2) + (COLOR_W+3)'(green);
  assign blue_ext = (COLOR_W+3)'(blue);
  assign qualify  = (blue_ext > red_x5) && (blue_ext > green_x5);

  assign col_sum_add = (SUM_W+1)'(col_sum_r) + (SUM_W+1)'(col_r);
  assign row_sum_add = (SUM_W+1)'(row_sum_r) + (SUM_W+1)'(row_r);
  // A hit that would overflow the count or either sum is dropped.
  assign room = (hit_r != {HIT_W{1'b1}}) && !col_sum_add[SUM_W] && !row_sum_add[SUM_W];

  always_comb begin
    if (height == '0) begin
      eff_h = EH_W'(1);
    end else if (32'(height) > 32'(FRAME_DIM_MAX)) begin
      eff_h = EH_W'(FRAME_DIM_MAX);
    end else begin
      eff_h = EH_W'(height);
    end
  end

  assign row_inc = EH_W'(row_r) + EH_W'(1);

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    col_sum_nxt = col_sum_r;
    row_sum_nxt = row_sum_r;
    hit_nxt     = hit_r;
    if (clear) begin
      col_nxt     = '0;
      row_nxt     = '0;
      col_sum_nxt = '0;
      row_sum_nxt = '0;
      hit_nxt     = '0;
    end else if (pix_valid) begin
      if (qualify && room) begin
        col_sum_nxt = col_sum_add[SUM_W-1:0];
        row_sum_nxt = row_sum_add[SUM_W-1:0];
        hit_nxt     = hit_r + HIT_W'(1);
      end
      // The row may sit above a height that was lowered mid-frame; it wraps too.
      if (row_inc >= eff_h) begin
        row_nxt = '0;
        if (col_r != COORD_W'(FRAME_DIM_MAX - 1)) begin
          col_nxt = col_r + COORD_W'(1);
        end
      end else begin
        row_nxt = row_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      col_sum_r <= '0;
      row_sum_r <= '0;
      hit_r     <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      col_sum_r <= col_sum_nxt;
      row_sum_r <= row_sum_nxt;
      hit_r     <= hit_nxt;
    end
  end

  assign col_sum   = col_sum_r;
  assign row_sum   = row_sum_r;
  assign hit_count = hit_r;

endmodule

FILE: hw/rtl/bbc_divider.sv
// ----------------------------------------------------------------------------
// Blue blob centroid divider
// Restoring divider with one compare-subtract per cycle, one quotient bit each.
// ----------------------------------------------------------------------------
module bbc_divider import bbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [HIT_W-1:0]   divisor,
  output bbc_div_stat_t      stat,
  output logic [COORD_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [ITER_W-1:0]  cnt_r, cnt_nxt;
  logic [CMP_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [COORD_W-1:0] quo_r, quo_nxt;

  logic [CMP_W-1:0]   dvs_ext;
  logic               ge;

  // The mean never exceeds the largest coordinate, so COORD_W quotient bits
  // cover it and the divisor starts shifted up by COORD_W-1.
  assign dvs_ext = CMP_W'(dvs_r);
  assign ge      = rem_r >= dvs_ext;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ITER_W'(COORD_W);
      rem_nxt  = CMP_W'(dividend);
      dvs_nxt  = DVS_W'(divisor) << (COORD_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dvs_ext;
      end
      quo_nxt = (quo_r << 1) | COORD_W'(ge);
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r) && $past(cnt_r) == ITER_W'(1))
    else $error("divider done without a final iteration");

endmodule

FILE: hw/rtl/blue_blob_centroid_top.sv
// Throughput: a pixel without end of frame is taken every cycle.
// After the end-of-frame pixel the sequencer runs two passes of the shared
// divider, on the column sum and then on the row sum, and the result is
// held until transferred; no pixel is taken meanwhile.
// Reset: synchronous active-low rst_n clears all sums, counters and the
// sequencer, and sets the height register height_r to 1024.
// ----------------------------------------------------------------------------
// Blue blob centroid top level
// Stream interface, configuration register and sequencer around the
// accumulator and the shared divider.
// ----------------------------------------------------------------------------
module blue_blob_centroid_top import bbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  input  logic                   in_tlast,   // end_of_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // centre_x, centre_y, zero pad
  output logic                   out_tuser,  // found
  input  logic                   cfg_wr_en,
  input  logic [HEIGHT_W-1:0]    cfg_wr_data
);

  bbc_state_t state_r, state_nxt;

  logic [HEIGHT_W-1:0] height_r;
  logic                found_r, found_nxt;
  logic [CENTRE_W-1:0] cx_r, cx_nxt;
  logic [CENTRE_W-1:0] cy_r, cy_nxt;

  logic                pix_valid;
  logic                acc_clear;
  logic [SUM_W-1:0]    col_sum;
  logic [SUM_W-1:0]    row_sum;
  logic [HIT_W-1:0]    hit_count;
  logic                hit_nz;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  bbc_div_stat_t       div_stat;
  logic [COORD_W-1:0]  quotient;
  logic [CENTRE_W-1:0] mean;

  assign pix_valid = in_tvalid && in_tready;
  assign hit_nz    = hit_count != '0;
  assign mean      = hit_nz ? CENTRE_W'(quotient) : '0;

  bbc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .red       (in_tdata[COLOR_W-1:0]),
    .green     (in_tdata[2*COLOR_W-1:COLOR_W]),
    .blue      (in_tdata[3*COLOR_W-1:2*COLOR_W]),
    .height    (height_r),
    .clear     (acc_clear),
    .col_sum   (col_sum),
    .row_sum   (row_sum),
    .hit_count (hit_count)
  );

  bbc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (hit_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (pix_valid && in_tlast) state_nxt = ST_START_X;
      ST_START_X: state_nxt = ST_DIV_X;
      ST_DIV_X:   if (div_stat.done) state_nxt = ST_START_Y;
      ST_START_Y: state_nxt = ST_DIV_Y;
      ST_DIV_Y:   if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:     if (out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    div_start    = 1'b0;
    div_dividend = col_sum;
    acc_clear    = 1'b0;
    found_nxt    = found_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_START_X: div_start = 1'b1;
      ST_DIV_X:   if (div_stat.done) cx_nxt = mean;
      ST_START_Y: begin
        div_start    = 1'b1;
        div_dividend = row_sum;
      end
      ST_DIV_Y: begin
        // Result is latched and the frame state cleared on the same edge.
        if (div_stat.done) begin
          cy_nxt    = mean;
          found_nxt = hit_nz;
          acc_clear = 1'b1;
        end
      end
      ST_OUT:     out_tvalid = 1'b1;
      default:    in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      height_r <= HEIGHT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        height_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
  end

  assign out_tuser = found_r;
  assign out_tdata = {(OUT_TDATA_W - 2*CENTRE_W)'(0), cy_r, cx_r};

  a_eof_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("pixel taken right after end of frame");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready && !div_stat.busy)
    else $error("result pending while input or divider active");

  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata == '0)
    else $error("nonzero centre without a hit");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> hit_count == '0)
    else $error("frame state not cleared after result");

endmodule
